// ===== hw/rtl/deq_pkg.sv =====
package deq_pkg;

    localparam int DEQ_DEPTH = 16;

    localparam logic [2:0] MODE_ADD_FRONT = 3'd0;
    localparam logic [2:0] MODE_ADD_REAR  = 3'd1;
    localparam logic [2:0] MODE_REM_FRONT = 3'd2;
    localparam logic [2:0] MODE_REM_REAR  = 3'd3;
    localparam logic [2:0] MODE_LIST      = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_UNDER = 2'd1;
    localparam logic [1:0] STAT_OVER  = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic       push_front;
        logic       push_rear;
        logic       pop_front;
        logic       pop_rear;
        logic       list_first;
        logic       list_next;
        logic       out_load;
        logic       out_use_data;
        logic       out_last;
        logic [1:0] out_status;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic list_done;
        logic out_free;
    } t_stat;

endpackage

// ===== hw/rtl/double_ended_queue.sv =====
// Bounded double-ended queue of DEPTH signed 32-bit words in a ring memory.
// Modes: add front, add rear, remove front, remove rear, list. An add's
// result word is registered in the cycle after acceptance; a removal goes
// through the registered memory read, then the output register load. A
// listing of N entries gives N words, one per cycle while the output is not
// stalled, the last flagged by o_last_of_run; input stalls for the whole run.
// An empty listing, an add to a full deque and a removal from an empty deque
// give one word with a status code and item value zero. Unused mode codes are
// dropped with no result. The single memory read port sets the listing pace.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_mode,
    input  logic signed [31:0] i_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_item_value,
    output logic               o_last_of_run,
    output logic [1:0]         o_status
);
    import deq_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_mode),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    deq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_value       (i_value),
        .i_out_stall   (i_out_stall),
        .o_stat        (stat),
        .o_out_valid   (o_out_valid),
        .o_item_value  (o_item_value),
        .o_last_of_run (o_last_of_run),
        .o_status      (o_status)
    );

endmodule

// ===== hw/rtl/deq_ctrl.sv =====
module deq_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [2:0]     i_mode,
    input  deq_pkg::t_stat i_stat,
    output logic           o_in_stall,
    output deq_pkg::t_cmd  o_cmd
);
    import deq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_LIST = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_stall = !((r_state == S_IDLE) && i_stat.out_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_mode)
                        MODE_ADD_FRONT, MODE_ADD_REAR: begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = 1'b1;
                            if (i_stat.full) begin
                                o_cmd.out_status = STAT_OVER;
                            end else begin
                                o_cmd.out_status = STAT_OK;
                                o_cmd.push_front = (i_mode == MODE_ADD_FRONT);
                                o_cmd.push_rear  = (i_mode == MODE_ADD_REAR);
                            end
                        end
                        MODE_REM_FRONT, MODE_REM_REAR: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = STAT_UNDER;
                            end else begin
                                o_cmd.pop_front = (i_mode == MODE_REM_FRONT);
                                o_cmd.pop_rear  = (i_mode == MODE_REM_REAR);
                                n_state         = S_POP;
                            end
                        end
                        MODE_LIST: begin
                            if (i_stat.empty) begin
                                o_cmd.out_load   = 1'b1;
                                o_cmd.out_last   = 1'b1;
                                o_cmd.out_status = STAT_EMPTY;
                            end else begin
                                o_cmd.list_first = 1'b1;
                                n_state          = S_LIST;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_use_data = 1'b1;
                    o_cmd.out_last     = 1'b1;
                    o_cmd.out_status   = STAT_OK;
                    n_state            = S_IDLE;
                end
            end
            S_LIST: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load     = 1'b1;
                    o_cmd.out_use_data = 1'b1;
                    o_cmd.out_last     = i_stat.list_done;
                    o_cmd.out_status   = STAT_OK;
                    if (i_stat.list_done) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.list_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== hw/rtl/deq_dpath.sv =====
module deq_dpath #(
    parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  deq_pkg::t_cmd      i_cmd,
    input  logic signed [31:0] i_value,
    input  logic               i_out_stall,
    output deq_pkg::t_stat     o_stat,
    output logic               o_out_valid,
    output logic signed [31:0] o_item_value,
    output logic               o_last_of_run,
    output logic [1:0]         o_status
);
    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = IW + 1;

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rd_data;
    logic [IW-1:0]      r_front;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      r_list_idx;
    logic               r_out_valid;
    logic signed [31:0] r_item;
    logic               r_last;
    logic [1:0]         r_status;

    logic [IW-1:0] front_dec;
    logic [IW-1:0] front_inc;
    logic [IW-1:0] wr_addr;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic          rd_en;

    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = {1'b0, base} + SW'(off);
        if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign front_dec = (r_front == '0) ? IW'(DEPTH - 1) : r_front - IW'(1);
    assign front_inc = (r_front == IW'(DEPTH - 1)) ? '0 : r_front + IW'(1);

    assign wr_en   = i_cmd.push_front || i_cmd.push_rear;
    assign wr_addr = i_cmd.push_front ? front_dec : wrap_add(r_front, r_count);

    assign rd_en = i_cmd.pop_front || i_cmd.pop_rear || i_cmd.list_first
                   || i_cmd.list_next;

    always_comb begin
        if (i_cmd.pop_front || i_cmd.list_first) begin
            rd_addr = r_front;
        end else if (i_cmd.pop_rear) begin
            rd_addr = wrap_add(r_front, r_count - CW'(1));
        end else begin
            rd_addr = wrap_add(r_front, r_list_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_list_idx <= '0;
        end else begin
            if (i_cmd.push_front) begin
                r_front <= front_dec;
            end else if (i_cmd.pop_front) begin
                r_front <= front_inc;
            end
            if (wr_en) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.pop_front || i_cmd.pop_rear) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.list_first) begin
                r_list_idx <= CW'(1);
            end else if (i_cmd.list_next) begin
                r_list_idx <= r_list_idx + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_item   <= i_cmd.out_use_data ? r_rd_data : '0;
            r_last   <= i_cmd.out_last;
            r_status <= i_cmd.out_status;
        end
    end

    assign o_stat.full      = (r_count == CW'(DEPTH));
    assign o_stat.empty     = (r_count == '0);
    assign o_stat.list_done = (r_list_idx == r_count);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid   = r_out_valid;
    assign o_item_value  = r_item;
    assign o_last_of_run = r_last;
    assign o_status      = r_status;

endmodule

// ===== hw/rtl/deq_chk.sv =====
module deq_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [2:0]         i_mode,
    input logic signed [31:0] i_value,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [31:0] o_item_value,
    input logic               o_last_of_run,
    input logic [1:0]         o_status
);
    import deq_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_item_value)
            && $stable(o_last_of_run) && $stable(o_status))
        else $error("stalled output word changed");

    a_add_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_mode == MODE_ADD_FRONT || i_mode == MODE_ADD_REAR)
        |=> o_out_valid && o_last_of_run && o_item_value == '0
            && (o_status == STAT_OK || o_status == STAT_OVER))
        else $error("add did not produce its result word");

    a_drop_unused: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode != MODE_ADD_FRONT && i_mode != MODE_ADD_REAR
            && i_mode != MODE_REM_FRONT && i_mode != MODE_REM_REAR
            && i_mode != MODE_LIST
        |=> !o_out_valid && !o_in_stall)
        else $error("unused mode produced a word or stalled input");

    a_flag_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != STAT_OK |-> o_last_of_run && o_item_value == '0)
        else $error("status word is not a lone zero word");

    a_run_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> o_in_stall)
        else $error("input accepted in the middle of a listing");

endmodule

bind double_ended_queue deq_chk u_deq_chk (.*);
